>>> src/ghp_pkg.sv
// Package: phase and status codes, header constants and section selection for the gzip header parser.
`default_nettype none

package ghp_pkg;

  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned OffsetWidth      = 32;

  localparam logic [7:0] MagicByte0   = 8'h1f;
  localparam logic [7:0] MagicByte1   = 8'h8b;
  localparam logic [7:0] MethodDeflate = 8'h08;
  localparam logic [7:0] FlagReserved = 8'hE0;
  localparam logic [7:0] FlagExtra    = 8'h04;
  localparam logic [7:0] FlagName     = 8'h08;
  localparam logic [7:0] FlagComment  = 8'h10;
  localparam logic [7:0] FlagHcrc     = 8'h02;
  localparam int unsigned FixedHeaderLen = 10;

  typedef enum logic [3:0] {
    PH_MAG0  = 4'd0,
    PH_MAG1  = 4'd1,
    PH_METH  = 4'd2,
    PH_FLG   = 4'd3,
    PH_FIX   = 4'd4,
    PH_XLO   = 4'd5,
    PH_XHI   = 4'd6,
    PH_XDAT  = 4'd7,
    PH_NAME  = 4'd8,
    PH_CMT   = 4'd9,
    PH_CRC0  = 4'd10,
    PH_CRC1  = 4'd11,
    PH_PAY   = 4'd12,
    PH_EMAG  = 4'd13,
    PH_EMETH = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    ST_HEADER    = 3'd0,
    ST_LAST      = 3'd1,
    ST_PAYLOAD   = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_BAD_METH  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  function automatic phase_e next_section(input phase_e from, input logic [7:0] flags);
    phase_e res;
    res = PH_PAY;
    if (from <= PH_CRC0 && (flags & FlagHcrc) != 8'h00) res = PH_CRC0;
    if (from <= PH_CMT && (flags & FlagComment) != 8'h00) res = PH_CMT;
    if (from <= PH_NAME && (flags & FlagName) != 8'h00) res = PH_NAME;
    if (from <= PH_XLO && (flags & FlagExtra) != 8'h00) res = PH_XLO;
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/ghp_in_stage.sv
// Input register stage: capture one byte transfer and hold it until the core takes it.
`default_nettype none

module ghp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ghp_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ghp_pkg::in_item_t      out_item_o
);
  import ghp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/ghp_core.sv
// Parser core: header phase machine, saturating byte count and the registered result.
`default_nettype none

module ghp_core #(
  parameter int unsigned CountBits = ghp_pkg::CountBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ghp_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [31:0]            end_offset_o,
  output logic [7:0]             flags_value_o
);
  import ghp_pkg::*;

  phase_e               phase_q, phase_d, phase_base;
  logic [CountBits-1:0] count_q, count_d, count_base;
  logic [7:0]           flags_q, flags_d, flags_base;
  logic [15:0]          extra_q, extra_d, extra_base, extra_dec;
  logic                 take;
  logic [7:0]           b;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [OffsetWidth-1:0] offset_q, offset_d;
  logic [7:0]           oflags_q;

  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign take          = in_valid_i && in_ready_o;
  assign b             = in_item_i.data_byte;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign end_offset_o  = offset_q;
  assign flags_value_o = oflags_q;

  always_comb begin
    phase_base = phase_q;
    count_base = count_q;
    flags_base = flags_q;
    extra_base = extra_q;
    if (in_item_i.first) begin
      phase_base = PH_MAG0;
      count_base = '0;
      flags_base = '0;
      extra_base = '0;
    end
  end

  assign extra_dec = (extra_base == 16'd0) ? 16'd0 : extra_base - 16'd1;

  always_comb begin
    phase_d = phase_base;
    count_d = count_base;
    flags_d = flags_base;
    extra_d = extra_base;
    if (phase_base < PH_PAY) begin
      if (count_base != {CountBits{1'b1}}) begin
        count_d = count_base + {{(CountBits-1){1'b0}}, 1'b1};
      end
      case (phase_base)
        PH_MAG0: phase_d = (b == MagicByte0) ? PH_MAG1 : PH_EMAG;
        PH_MAG1: phase_d = (b == MagicByte1) ? PH_METH : PH_EMAG;
        PH_METH: phase_d = (b == MethodDeflate) ? PH_FLG : PH_EMETH;
        PH_FLG: begin
          flags_d = b;
          phase_d = ((b & FlagReserved) != 8'h00) ? PH_EMETH : PH_FIX;
        end
        PH_FIX: begin
          if (count_d >= CountBits'(FixedHeaderLen)) begin
            phase_d = next_section(PH_XLO, flags_base);
          end
        end
        PH_XLO: begin
          extra_d = {8'h00, b};
          phase_d = PH_XHI;
        end
        PH_XHI: begin
          extra_d = {b, extra_base[7:0]};
          phase_d = ({b, extra_base[7:0]} != 16'd0) ? PH_XDAT
                                                     : next_section(PH_NAME, flags_base);
        end
        PH_XDAT: begin
          extra_d = extra_dec;
          if (extra_dec == 16'd0) begin
            phase_d = next_section(PH_NAME, flags_base);
          end
        end
        PH_NAME: begin
          if (b == 8'h00) begin
            phase_d = next_section(PH_CMT, flags_base);
          end
        end
        PH_CMT: begin
          if (b == 8'h00) begin
            phase_d = next_section(PH_CRC0, flags_base);
          end
        end
        PH_CRC0: phase_d = PH_CRC1;
        default: phase_d = PH_PAY;
      endcase
    end
  end

  always_comb begin
    case (phase_d)
      PH_EMAG:  status_d = ST_BAD_MAGIC;
      PH_EMETH: status_d = ST_BAD_METH;
      PH_PAY:   status_d = (phase_base == PH_PAY) ? ST_PAYLOAD : ST_LAST;
      default:  status_d = ST_HEADER;
    endcase
  end

  generate
    if (CountBits > OffsetWidth) begin : g_wide
      assign offset_d = (|count_d[CountBits-1:OffsetWidth]) ? {OffsetWidth{1'b1}}
                                                             : count_d[OffsetWidth-1:0];
    end else if (CountBits == OffsetWidth) begin : g_equal
      assign offset_d = count_d;
    end else begin : g_narrow
      assign offset_d = {{(OffsetWidth-CountBits){1'b0}}, count_d};
    end
  endgenerate

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAG0;
      count_q     <= '0;
      flags_q     <= '0;
      extra_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q <= phase_d;
        count_q <= count_d;
        flags_q <= flags_d;
        extra_q <= extra_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      offset_q <= offset_d;
      oflags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

>>> src/gzip_header_parser.sv
// Top level of the gzip member header parser.
//
// Usage: feed a gzip stream one byte per transfer on the s_axis channel;
// tdata carries the byte and tuser marks the first byte of a new stream,
// which restarts the parser. Every byte yields exactly one m_axis transfer
// with its status (header, last header byte, payload, bad magic, bad
// method or reserved flags), the saturating header length so far and the
// flag byte once seen. Errors stick until the next first-marked byte.
// Path: each byte passes the input register, then the phase update into
// the result register, from which it is offered on m_axis.
// Throughput: one byte per cycle while m_axis_tready_i is high; the
// phase, count and extra-length update is a single short step between
// the two registers.
// Reset: the parser expects the first magic byte with all counts cleared,
// so a stream may start without the first mark; no result is pending.
// Stall: while m_axis_tready_i is low the result holds, the input register
// fills, and then s_axis_tready_o drops; no transfer is lost.
`default_nettype none

module gzip_header_parser #(
  parameter int unsigned COUNT_BITS = ghp_pkg::CountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // [2:0] status, [34:3] end_offset,
                                             // [42:35] flags_value, [47:43] zero
);
  import ghp_pkg::*;

  in_item_t   in_item, stage_item;
  logic       stage_valid, core_ready;
  logic [2:0] status;
  logic [31:0] end_offset;
  logic [7:0] flags_value;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.first     = s_axis_tuser_i;

  ghp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (stage_valid),
    .out_ready_i (core_ready),
    .out_item_o  (stage_item)
  );

  ghp_core #(
    .CountBits (COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (stage_valid),
    .in_ready_o    (core_ready),
    .in_item_i     (stage_item),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .end_offset_o  (end_offset),
    .flags_value_o (flags_value)
  );

  assign m_axis_tdata_o = {5'b00000, flags_value, end_offset, status};

endmodule

`default_nettype wire
